// ===== design/ycc2rgb_pkg.sv =====
`timescale 1ns / 1ps

package ycc2rgb_pkg;

  // Pipeline depth: input offsets, products, sums, saturation.
  localparam int unsigned NumStages = 4;
  localparam int unsigned NumCoefs  = 7;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PixW      = 8;
  localparam int unsigned OffW      = PixW + 1;          // offset-removed sample
  localparam int unsigned ProdW     = OffW + CoefW;      // one product
  localparam int unsigned SumW      = ProdW + 2;         // sum of up to three products
  localparam int unsigned OutShift  = 12;

  localparam logic signed [OffW-1:0] LumaOffset   = 9'sd16;
  localparam logic signed [OffW-1:0] ChromaOffset = 9'sd128;
  localparam logic [PixW-1:0]        PixMax       = 8'hff;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgLumaRed   = 3'd0,
    CfgCrRed     = 3'd1,
    CfgLumaGreen = 3'd2,
    CfgCbGreen   = 3'd3,
    CfgCrGreen   = 3'd4,
    CfgLumaBlue  = 3'd5,
    CfgCbBlue    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoefW-1:0] luma_red;
    logic signed [CoefW-1:0] cr_red;
    logic signed [CoefW-1:0] luma_green;
    logic signed [CoefW-1:0] cb_green;
    logic signed [CoefW-1:0] cr_green;
    logic signed [CoefW-1:0] luma_blue;
    logic signed [CoefW-1:0] cb_blue;
  } coef_set_t;

  localparam coef_set_t CoefReset = '{
    luma_red:   16'sd4788,
    cr_red:     16'sd6563,
    luma_green: 16'sd4788,
    cb_green:   -16'sd1611,
    cr_green:   -16'sd3343,
    luma_blue:  16'sd4788,
    cb_blue:    16'sd8295
  };

  typedef struct packed {
    logic [15:0] luma_pair;
    logic [15:0] cb_pair;
    logic [15:0] cr_pair;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] red_pair;
    logic [15:0] green_pair;
    logic [15:0] blue_pair;
    logic        last_out;
  } out_beat_t;

  // Per-stage load enables and the valid bits that travel with the data.
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

  // Arithmetic shift right by OutShift and clamp to 0..255.
  function automatic logic [PixW-1:0] sat_pixel(input logic signed [SumW-1:0] acc);
    logic [PixW-1:0] res;
    if (acc[SumW-1]) begin
      res = '0;
    end else if (|acc[SumW-2:OutShift+PixW]) begin
      res = PixMax;
    end else begin
      res = acc[OutShift+PixW-1:OutShift];
    end
    return res;
  endfunction

endpackage

// ===== design/ycbcr_to_rgb_pixel_pair_unit.sv =====
// An accepted input beat passes the offset, product, sum and saturation stages.
// Throughput: one pixel pair per cycle while the output does not stall; the
// four-stage multiply-add pipeline sets the latency. A stalled output freezes
// the full stages behind it; empty stages keep filling until the input stalls.
// Reset (rst_ni low, asynchronous): all stage valid bits clear and the seven
// coefficients return to their BT.601 defaults.
`timescale 1ns / 1ps

module ycbcr_to_rgb_pixel_pair_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ycc2rgb_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ycc2rgb_pkg::CoefW-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  ycc2rgb_pkg::in_beat_t                 in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output ycc2rgb_pkg::out_beat_t                out_data_o
);

  localparam int unsigned N    = ycc2rgb_pkg::NumStages;
  localparam int unsigned PixW = ycc2rgb_pkg::PixW;

  ycc2rgb_pkg::coef_set_t  coef_q, coef_d;
  ycc2rgb_pkg::pipe_ctrl_t ctrl;
  logic [N-1:0]            last_q;
  logic [PixW-1:0]         red_a, green_a, blue_a, red_b, green_b, blue_b;

  // Coefficient registers. The user must write them only while the pipeline is
  // empty; the block does not enforce it, and the datapath reads them directly
  // without shadowing. An index past the last register is ignored.
  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      case (ycc2rgb_pkg::cfg_idx_e'(cfg_idx_i))
        ycc2rgb_pkg::CfgLumaRed:   coef_d.luma_red   = cfg_wdata_i;
        ycc2rgb_pkg::CfgCrRed:     coef_d.cr_red     = cfg_wdata_i;
        ycc2rgb_pkg::CfgLumaGreen: coef_d.luma_green = cfg_wdata_i;
        ycc2rgb_pkg::CfgCbGreen:   coef_d.cb_green   = cfg_wdata_i;
        ycc2rgb_pkg::CfgCrGreen:   coef_d.cr_green   = cfg_wdata_i;
        ycc2rgb_pkg::CfgLumaBlue:  coef_d.luma_blue  = cfg_wdata_i;
        ycc2rgb_pkg::CfgCbBlue:    coef_d.cb_blue    = cfg_wdata_i;
        default: coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= ycc2rgb_pkg::CoefReset;
    end else begin
      coef_q <= coef_d;
    end
  end

  // Stage control: each stage carries a valid bit and loads when it is empty
  // or its successor drains, so a stall anywhere downstream freezes only the
  // stages that are full behind it.
  ycc2rgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // Pixel A sits in the low byte of each word, pixel B in the high byte.
  ycc2rgb_lane u_lane_a (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .coef_i  (coef_q),
    .luma_i  (in_data_i.luma_pair[PixW-1:0]),
    .cb_i    (in_data_i.cb_pair[PixW-1:0]),
    .cr_i    (in_data_i.cr_pair[PixW-1:0]),
    .red_o   (red_a),
    .green_o (green_a),
    .blue_o  (blue_a)
  );

  ycc2rgb_lane u_lane_b (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .coef_i  (coef_q),
    .luma_i  (in_data_i.luma_pair[2*PixW-1:PixW]),
    .cb_i    (in_data_i.cb_pair[2*PixW-1:PixW]),
    .cr_i    (in_data_i.cr_pair[2*PixW-1:PixW]),
    .red_o   (red_b),
    .green_o (green_b),
    .blue_o  (blue_b)
  );

  // The frame-end flag rides along with the pixel data, stage by stage.
  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      last_q[0] <= in_data_i.last_in;
    end
    for (int k = 1; k < N; k++) begin
      if (ctrl.load[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign out_valid_o           = ctrl.valid[N-1];
  assign out_data_o.red_pair   = {red_b, red_a};
  assign out_data_o.green_pair = {green_b, green_a};
  assign out_data_o.blue_pair  = {blue_b, blue_a};
  assign out_data_o.last_out   = last_q[N-1];

  // The input stalls only when every stage holds a beat.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&ctrl.valid))
    else $error("input stalled with an empty stage");

  // A full stage whose successor does not load keeps its beat.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.valid[N-2] && !ctrl.load[N-1]) |=> ctrl.valid[N-2])
    else $error("beat lost in the sum stage");

  // An accepted beat reaches the first stage.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ctrl.valid[0])
    else $error("accepted beat did not enter the pipeline");

  // Coefficients change only through a write.
  a_coef_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(coef_q))
    else $error("coefficient changed without a write");

endmodule

// ===== design/ycc2rgb_ctrl.sv =====
`timescale 1ns / 1ps

// Valid/stall control for the datapath stages. A stage loads whenever it is
// empty or the stage after it moves on in the same cycle.
module ycc2rgb_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    out_stall_i,
  output ycc2rgb_pkg::pipe_ctrl_t ctrl_o
);

  localparam int unsigned N = ycc2rgb_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] ready;

  always_comb begin
    ready[N-1] = !valid_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o   = !ready[0];
  assign ctrl_o.load  = ready;
  assign ctrl_o.valid = valid_q;

endmodule

// ===== design/ycc2rgb_lane.sv =====
`timescale 1ns / 1ps

// One pixel through four stages: offset removal, products, sums, saturation.
module ycc2rgb_lane (
  input  logic                                 clk_i,
  input  ycc2rgb_pkg::pipe_ctrl_t              ctrl_i,
  input  ycc2rgb_pkg::coef_set_t               coef_i,
  input  logic [ycc2rgb_pkg::PixW-1:0]         luma_i,
  input  logic [ycc2rgb_pkg::PixW-1:0]         cb_i,
  input  logic [ycc2rgb_pkg::PixW-1:0]         cr_i,
  output logic [ycc2rgb_pkg::PixW-1:0]         red_o,
  output logic [ycc2rgb_pkg::PixW-1:0]         green_o,
  output logic [ycc2rgb_pkg::PixW-1:0]         blue_o
);

  localparam int unsigned OffW  = ycc2rgb_pkg::OffW;
  localparam int unsigned ProdW = ycc2rgb_pkg::ProdW;
  localparam int unsigned SumW  = ycc2rgb_pkg::SumW;

  logic signed [OffW-1:0]  y_d, u_d, v_d, y_q, u_q, v_q;
  logic signed [ProdW-1:0] r_y_q, r_v_q, g_y_q, g_u_q, g_v_q, b_y_q, b_u_q;
  logic signed [SumW-1:0]  r_sum_q, g_sum_q, b_sum_q;
  logic [ycc2rgb_pkg::PixW-1:0] red_q, green_q, blue_q;

  assign y_d = $signed({1'b0, luma_i}) - ycc2rgb_pkg::LumaOffset;
  assign u_d = $signed({1'b0, cb_i}) - ycc2rgb_pkg::ChromaOffset;
  assign v_d = $signed({1'b0, cr_i}) - ycc2rgb_pkg::ChromaOffset;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      y_q <= y_d;
      u_q <= u_d;
      v_q <= v_d;
    end
    if (ctrl_i.load[1]) begin
      r_y_q <= y_q * coef_i.luma_red;
      r_v_q <= v_q * coef_i.cr_red;
      g_y_q <= y_q * coef_i.luma_green;
      g_u_q <= u_q * coef_i.cb_green;
      g_v_q <= v_q * coef_i.cr_green;
      b_y_q <= y_q * coef_i.luma_blue;
      b_u_q <= u_q * coef_i.cb_blue;
    end
    if (ctrl_i.load[2]) begin
      r_sum_q <= SumW'(r_y_q) + SumW'(r_v_q);
      g_sum_q <= SumW'(g_y_q) + SumW'(g_u_q) + SumW'(g_v_q);
      b_sum_q <= SumW'(b_y_q) + SumW'(b_u_q);
    end
    if (ctrl_i.load[3]) begin
      red_q   <= ycc2rgb_pkg::sat_pixel(r_sum_q);
      green_q <= ycc2rgb_pkg::sat_pixel(g_sum_q);
      blue_q  <= ycc2rgb_pkg::sat_pixel(b_sum_q);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ===== bench/ycc2rgb_checker.sv =====
`timescale 1ns / 1ps

module ycc2rgb_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ycc2rgb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ycc2rgb_pkg::CoefW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  ycc2rgb_pkg::in_beat_t             in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  ycc2rgb_pkg::out_beat_t            out_data_i,
  output int unsigned                       errors_o,
  output int unsigned                       pending_o
);

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned PixW        = ycc2rgb_pkg::PixW;

  ycc2rgb_pkg::coef_set_t  coefs_now;
  ycc2rgb_pkg::out_beat_t  rgb_due[$];
  int unsigned             mismatch_count;

  function automatic logic [PixW-1:0] clamp_pixel(input int acc);
    int q;
    if (acc < 0) begin
      return '0;
    end
    q = acc >>> ycc2rgb_pkg::OutShift;
    if (q > int'(ycc2rgb_pkg::PixMax)) begin
      return ycc2rgb_pkg::PixMax;
    end
    return q[PixW-1:0];
  endfunction

  // Both byte lanes go through the same BT.601 sums of products.
  function automatic ycc2rgb_pkg::out_beat_t predict_rgb_pair(
      input ycc2rgb_pkg::in_beat_t px, input ycc2rgb_pkg::coef_set_t c);
    ycc2rgb_pkg::out_beat_t rgb;
    int        y;
    int        u;
    int        v;
    for (int lane = 0; lane < 2; lane++) begin
      y = int'(px.luma_pair[lane*PixW +: PixW]) - int'(ycc2rgb_pkg::LumaOffset);
      u = int'(px.cb_pair[lane*PixW +: PixW]) - int'(ycc2rgb_pkg::ChromaOffset);
      v = int'(px.cr_pair[lane*PixW +: PixW]) - int'(ycc2rgb_pkg::ChromaOffset);
      rgb.red_pair[lane*PixW +: PixW] =
        clamp_pixel(y * int'($signed(c.luma_red)) + v * int'($signed(c.cr_red)));
      rgb.green_pair[lane*PixW +: PixW] =
        clamp_pixel(y * int'($signed(c.luma_green)) + u * int'($signed(c.cb_green))
                    + v * int'($signed(c.cr_green)));
      rgb.blue_pair[lane*PixW +: PixW] =
        clamp_pixel(y * int'($signed(c.luma_blue)) + u * int'($signed(c.cb_blue)));
    end
    rgb.last_out = px.last_in;
    return rgb;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ycc2rgb_pkg::out_beat_t want;
    if (!rst_ni) begin
      coefs_now = ycc2rgb_pkg::CoefReset;
      rgb_due.delete();
      mismatch_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        rgb_due.push_back(predict_rgb_pair(in_data_i, coefs_now));
      end
      if (out_valid_i && !out_stall_i) begin
        if (rgb_due.size() == 0) begin
          if (mismatch_count < ReportLimit) begin
            $display("%0t: unexpected beat r=%h g=%h b=%h last=%b", $realtime,
                     out_data_i.red_pair, out_data_i.green_pair, out_data_i.blue_pair,
                     out_data_i.last_out);
          end
          mismatch_count++;
        end else begin
          want = rgb_due.pop_front();
          if (want.red_pair !== out_data_i.red_pair ||
              want.green_pair !== out_data_i.green_pair ||
              want.blue_pair !== out_data_i.blue_pair ||
              want.last_out !== out_data_i.last_out) begin
            if (mismatch_count < ReportLimit) begin
              $display({"%0t: mismatch expected r=%h g=%h b=%h last=%b,",
                        " got r=%h g=%h b=%h last=%b"},
                       $realtime, want.red_pair, want.green_pair, want.blue_pair,
                       want.last_out, out_data_i.red_pair, out_data_i.green_pair,
                       out_data_i.blue_pair, out_data_i.last_out);
            end
            mismatch_count++;
          end
        end
      end
      // Writes to an index beyond the last coefficient are dropped.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ycc2rgb_pkg::CfgLumaRed:   coefs_now.luma_red   = cfg_wdata_i;
          ycc2rgb_pkg::CfgCrRed:     coefs_now.cr_red     = cfg_wdata_i;
          ycc2rgb_pkg::CfgLumaGreen: coefs_now.luma_green = cfg_wdata_i;
          ycc2rgb_pkg::CfgCbGreen:   coefs_now.cb_green   = cfg_wdata_i;
          ycc2rgb_pkg::CfgCrGreen:   coefs_now.cr_green   = cfg_wdata_i;
          ycc2rgb_pkg::CfgLumaBlue:  coefs_now.luma_blue  = cfg_wdata_i;
          ycc2rgb_pkg::CfgCbBlue:    coefs_now.cb_blue    = cfg_wdata_i;
          default: ;
        endcase
      end
      errors_o  <= mismatch_count;
      pending_o <= rgb_due.size();
    end
  end

endmodule

// ===== bench/tb_ycbcr_to_rgb_pixel_pair_unit.sv =====
`timescale 1ns / 1ps

module tb_ycbcr_to_rgb_pixel_pair_unit;

  localparam int unsigned CfgIdxW      = ycc2rgb_pkg::CfgIdxW;
  localparam int unsigned CoefW        = ycc2rgb_pkg::CoefW;
  localparam int unsigned NumCoefs     = ycc2rgb_pkg::NumCoefs;
  localparam int unsigned HalfPeriodNs = 5;
  // Far beyond the slowest legal run.
  localparam int unsigned RunLimitNs   = 5_000_000;
  // Length of the one long output hold-off that backs up the whole pipeline.
  localparam int unsigned LongHold     = 300;
  // First index past the coefficient bank; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(NumCoefs);

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx   = '0;
  logic [CoefW-1:0]       cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  ycc2rgb_pkg::in_beat_t  in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  ycc2rgb_pkg::out_beat_t out_data;

  int unsigned mismatches;
  int unsigned pending;

  // Handshake between the stimulus and the output-side process for the long
  // hold-off: the stimulus asks once, the output side serves it once.
  logic squeeze_req  = 1'b0;
  logic squeeze_done = 1'b0;

  // Beats left in the current input burst.
  int unsigned burst_left = 0;

  always #(HalfPeriodNs) clk = ~clk;

  ycbcr_to_rgb_pixel_pair_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // The checker snoops both channels and the register port, keeps its own
  // copy of the coefficients and compares every output beat in order.
  ycc2rgb_checker u_rgb_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  // One 8-bit sample. Style 0 is any byte, style 1 stays inside the studio
  // range and style 2 picks from the edges where clamping and offsets bite.
  function automatic logic [7:0] pick_sample(input int unsigned flavor);
    case (flavor)
      0: return 8'($urandom);
      1: return 8'($urandom_range(16, 240));
      default: begin
        case ($urandom_range(0, 5))
          0: return 8'h00;
          1: return 8'hff;
          2: return 8'h10;
          3: return 8'h80;
          4: return 8'heb;
          default: return 8'hf0;
        endcase
      end
    endcase
  endfunction

  function automatic ycc2rgb_pkg::in_beat_t random_pair();
    ycc2rgb_pkg::in_beat_t px;
    int unsigned flavor;
    flavor        = $urandom_range(0, 2);
    px.luma_pair  = {pick_sample(flavor), pick_sample(flavor)};
    px.cb_pair    = {pick_sample(flavor), pick_sample(flavor)};
    px.cr_pair    = {pick_sample(flavor), pick_sample(flavor)};
    // Frames of random length: roughly one pair in eight closes a frame.
    px.last_in    = ($urandom_range(0, 7) == 0);
    return px;
  endfunction

  function automatic ycc2rgb_pkg::in_beat_t pix_pair(input logic [15:0] y,
                                                     input logic [15:0] cb,
                                                     input logic [15:0] cr,
                                                     input logic last);
    ycc2rgb_pkg::in_beat_t px;
    px.luma_pair = y;
    px.cb_pair   = cb;
    px.cr_pair   = cr;
    px.last_in   = last;
    return px;
  endfunction

  // Each coefficient is drawn with a magnitude of at most span and a random
  // sign; a span of 32768 covers the whole 16-bit range.
  function automatic ycc2rgb_pkg::coef_set_t random_coefs(input int unsigned span);
    ycc2rgb_pkg::coef_set_t c;
    int        mag;
    for (int k = 0; k < NumCoefs; k++) begin
      mag = $urandom_range(0, span);
      c[k*CoefW +: CoefW] = $urandom_range(0, 1) ? CoefW'(-mag) : CoefW'(mag);
    end
    return c;
  endfunction

  // Offers one beat and holds it until accepted. Between bursts the valid
  // line drops for a random gap; a zero gap joins two bursts back to back.
  // The valid never looks at the stall, and the payload is held while stalled.
  task automatic send_pair(input ycc2rgb_pkg::in_beat_t px);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Stops offering and waits until every predicted beat has come out. The
  // pending count is registered in the checker, so the task samples it only
  // after the clock has advanced.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Loads all seven weights, then pokes the unused index with a value that
  // would change red if the write were not dropped.
  task automatic load_coefs(input ycc2rgb_pkg::coef_set_t c);
    write_reg(ycc2rgb_pkg::CfgLumaRed,   c.luma_red);
    write_reg(ycc2rgb_pkg::CfgCrRed,     c.cr_red);
    write_reg(ycc2rgb_pkg::CfgLumaGreen, c.luma_green);
    write_reg(ycc2rgb_pkg::CfgCbGreen,   c.cb_green);
    write_reg(ycc2rgb_pkg::CfgCrGreen,   c.cr_green);
    write_reg(ycc2rgb_pkg::CfgLumaBlue,  c.luma_blue);
    write_reg(ycc2rgb_pkg::CfgCbBlue,    c.cb_blue);
    write_reg(CfgIdxSpare,               ~c.luma_red);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_pair(random_pair());
    wait_drained();
  endtask

  // Output side: segments of random length with no stall, light stall, heavy
  // stall or an almost solid stall, plus one long hold-off on request while
  // the input keeps offering, so the pipeline fills and backs up.
  initial begin
    int unsigned seg_len;
    int unsigned mode;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        seg_len = $urandom_range(16, 160);
        mode    = $urandom_range(0, 3);
        for (int n = 0; n < seg_len && !(squeeze_req && !squeeze_done); n++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 15) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    ycc2rgb_pkg::coef_set_t swing;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats with the reset weights. Pairs are the only unit on this
    // interface, so a lone pixel of an odd-width line simply never appears.
    send_pair(pix_pair(16'h0000, 16'h0000, 16'h0000, 1'b0)); // all zero, red and blue sums negative
    send_pair(pix_pair(16'hffff, 16'hffff, 16'hffff, 1'b1)); // all ones, red and blue saturate
    send_pair(pix_pair(16'h1010, 16'h8080, 16'h8080, 1'b0)); // studio black
    send_pair(pix_pair(16'hebeb, 16'h8080, 16'h8080, 1'b0)); // studio white
    send_pair(pix_pair(16'h7e7e, 16'h8080, 16'h8080, 1'b1)); // mid grey
    send_pair(pix_pair(16'hffff, 16'hff00, 16'h00ff, 1'b0)); // lanes see opposite chroma
    send_pair(pix_pair(16'h10eb, 16'h80f0, 16'hf010, 1'b0)); // black and white mixed
    send_pair(pix_pair(16'hffeb, 16'h8080, 16'hffff, 1'b0)); // red forced high
    send_pair(pix_pair(16'hebeb, 16'h0000, 16'h0000, 1'b0)); // green forced high
    send_pair(pix_pair(16'hffff, 16'hffff, 16'h8080, 1'b0)); // blue forced high
    send_pair(pix_pair(16'h0010, 16'h00ff, 16'hff00, 1'b1)); // luma below black
    send_pair(pix_pair(16'h1010, 16'h0000, 16'hffff, 1'b0)); // chroma alone drives sums
    send_pair(pix_pair(16'haaaa, 16'h5555, 16'ha5a5, 1'b0)); // alternating bits
    send_pair(pix_pair(16'h5555, 16'haaaa, 16'h5a5a, 1'b1)); // inverted pattern
    send_pair(pix_pair(16'hf010, 16'h1080, 16'h80f0, 1'b0)); // chroma range edges
    send_pair(pix_pair(16'h0fff, 16'h7f81, 16'h817f, 1'b0)); // just off the offsets
    wait_drained();

    // Random beats with the reset weights; the long output hold-off lands here.
    squeeze_req <= 1'b1;
    run_random(280);

    // All weights at the positive extreme: nearly everything clamps.
    load_coefs(ycc2rgb_pkg::coef_set_t'{default: 16'sh7fff});
    run_random(150);

    // All weights at the negative extreme.
    load_coefs(ycc2rgb_pkg::coef_set_t'{default: 16'sh8000});
    run_random(150);

    // Full-range random weights.
    load_coefs(random_coefs(32768));
    run_random(200);

    // Moderate random weights keep many sums inside 0..255 after the shift.
    repeat (3) begin
      load_coefs(random_coefs(8191));
      run_random(100);
    end

    // Luma weights at one extreme and chroma weights at the other.
    swing = '{luma_red:   16'sh7fff, cr_red:   16'sh8000,
              luma_green: 16'sh7fff, cb_green: 16'sh8000, cr_green: 16'sh8000,
              luma_blue:  16'sh7fff, cb_blue:  16'sh8000};
    load_coefs(swing);
    run_random(150);

    // Back to the standard weights, written explicitly this time.
    load_coefs(ycc2rgb_pkg::CoefReset);
    run_random(280);

    // Everything has drained; keep clocking to expose any stray beat before the verdict.
    repeat (ycc2rgb_pkg::NumStages + 2) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
